// ===== design/two_region_event_buffer_core_defines.svh =====
// Assertion macros for the event buffer RTL.
`ifndef TWO_REGION_EVENT_BUFFER_CORE_DEFINES_SVH
`define TWO_REGION_EVENT_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TREB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("event buffer check failed");

// Next-cycle implication, disabled during reset.
`define TREB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("event buffer check failed");

`endif

// ===== design/treb_pkg.sv =====
// Shared constants and types for the two-region event buffer.
package treb_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int EW    = 32;
  localparam int IW    = 8;
  localparam int CMDW  = 3;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Command codes on the input stream
  localparam logic [CMDW-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMDW-1:0] CMD_APPEND_V = 3'd1;
  localparam logic [CMDW-1:0] CMD_APPEND_P = 3'd2;
  localparam logic [CMDW-1:0] CMD_READ_V   = 3'd3;
  localparam logic [CMDW-1:0] CMD_READ_P   = 3'd4;

  // Internal operation codes after classification
  localparam logic [2:0] OP_NOP      = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_APPEND_V = 3'd2;
  localparam logic [2:0] OP_APPEND_P = 3'd3;
  localparam logic [2:0] OP_READ_V   = 3'd4;
  localparam logic [2:0] OP_READ_P   = 3'd5;

  typedef struct packed {
    logic [2:0]    op;
    logic [EW-1:0] data;
    logic [IW-1:0] idx;
  } item_t;

endpackage

// ===== design/treb_front.sv =====
// Front end: takes input beats, decodes the command, queues work for the back end.
module treb_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // cmd[2:0], event_data[34:3], item_index[42:35], zero fill above
  input  logic [treb_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 item_valid,
  input  logic                                 item_ready,
  output treb_pkg::item_t                      item
);

  treb_pkg::item_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;
  logic [2:0]      op;
  logic [2:0]      cmd;

  assign cmd = s_tdata[2:0];

  always_comb begin
    case (cmd)
      treb_pkg::CMD_CLEAR:    op = treb_pkg::OP_CLEAR;
      treb_pkg::CMD_APPEND_V: op = treb_pkg::OP_APPEND_V;
      treb_pkg::CMD_APPEND_P: op = treb_pkg::OP_APPEND_P;
      treb_pkg::CMD_READ_V:   op = treb_pkg::OP_READ_V;
      treb_pkg::CMD_READ_P:   op = treb_pkg::OP_READ_P;
      default:                op = treb_pkg::OP_NOP;
    endcase
  end

  assign s_tready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];
  assign push       = s_tvalid && s_tready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op, data: s_tdata[34:3], idx: s_tdata[42:35]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/treb_back.sv =====
// Back end: entry store, region pointers, eviction shifter and result register.
module treb_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  treb_pkg::item_t                      item,
  input  logic [treb_pkg::CW-1:0]              floor,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [treb_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_PWRITE = 3'd2;
  localparam logic [2:0] ST_RESULT = 3'd3;

  localparam int CW = treb_pkg::CW;
  localparam int AW = treb_pkg::AW;
  localparam int EW = treb_pkg::EW;
  localparam logic [CW-1:0] DEPTH_C = CW'(treb_pkg::DEPTH);

  logic [EW-1:0] mem [treb_pkg::DEPTH];
  logic [EW-1:0] rdata;

  logic [2:0]    state, state_next;
  logic [CW-1:0] vcount, vcount_next;
  logic [CW-1:0] pstart, pstart_next;
  logic [AW-1:0] oldest, oldest_next;
  logic [AW-1:0] sh, sh_next;
  logic [EW-1:0] pdata, pdata_next;
  logic          hit, hit_next;
  logic          full, full_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;

  logic          met;
  logic [CW-1:0] sum;
  logic [CW-1:0] pos;
  logic [CW-1:0] oldest_inc;
  logic [CW-1:0] pst_dec;
  logic [CW-1:0] pcount;
  logic          out_free;

  assign met        = (vcount == pstart);
  assign oldest_inc = {1'b0, oldest} + CW'(1);
  assign sum        = {1'b0, oldest} + {1'b0, item.idx};
  // oldest and idx are both below vcount, so one subtract wraps the ring
  assign pos        = (sum >= vcount) ? sum - vcount : sum;
  assign pst_dec    = pstart - CW'(1);
  assign pcount     = DEPTH_C - pstart;
  assign out_free   = !m_tvalid || m_tready;
  assign item_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    vcount_next = vcount;
    pstart_next = pstart;
    oldest_next = oldest;
    sh_next     = sh;
    pdata_next  = pdata;
    hit_next    = hit;
    full_next   = full;
    we          = 1'b0;
    waddr       = '0;
    wdata       = pdata;
    re          = 1'b0;
    raddr       = '0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          hit_next   = 1'b0;
          full_next  = 1'b0;
          pdata_next = item.data;
          state_next = ST_RESULT;
          case (item.op)
            treb_pkg::OP_CLEAR: begin
              oldest_next = '0;
              vcount_next = '0;
              pstart_next = DEPTH_C;
            end
            treb_pkg::OP_APPEND_V: begin
              if (met) begin
                // ring mode: overwrite oldest, store full of persistent entries is a no-op
                if (vcount != '0) begin
                  we          = 1'b1;
                  waddr       = oldest;
                  wdata       = item.data;
                  oldest_next = (oldest_inc >= vcount) ? '0 : oldest_inc[AW-1:0];
                end
              end else begin
                we          = 1'b1;
                waddr       = vcount[AW-1:0];
                wdata       = item.data;
                vcount_next = vcount + CW'(1);
              end
            end
            treb_pkg::OP_APPEND_P: begin
              if (pstart <= floor || pstart == '0) begin
                full_next = 1'b1;
              end else if (met && vcount != '0 && oldest_inc < vcount) begin
                // evict oldest: move the entries above it down one slot
                re          = 1'b1;
                raddr       = oldest_inc[AW-1:0];
                sh_next     = oldest;
                vcount_next = vcount - CW'(1);
                state_next  = ST_SHIFT;
              end else begin
                if (met && vcount != '0) begin
                  oldest_next = '0;
                  vcount_next = vcount - CW'(1);
                end
                we          = 1'b1;
                waddr       = pst_dec[AW-1:0];
                wdata       = item.data;
                pstart_next = pst_dec;
              end
            end
            treb_pkg::OP_READ_V: begin
              if ({1'b0, item.idx} < vcount) begin
                re       = 1'b1;
                raddr    = pos[AW-1:0];
                hit_next = 1'b1;
              end
            end
            treb_pkg::OP_READ_P: begin
              if ({1'b0, item.idx} < pcount) begin
                re       = 1'b1;
                raddr    = ~item.idx;
                hit_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        we    = 1'b1;
        waddr = sh;
        wdata = rdata;
        // vcount already holds the reduced size here
        if ({1'b0, sh} + CW'(1) < vcount) begin
          re      = 1'b1;
          raddr   = sh + AW'(2);
          sh_next = sh + AW'(1);
        end else begin
          state_next = ST_PWRITE;
        end
      end
      ST_PWRITE: begin
        we          = 1'b1;
        waddr       = pst_dec[AW-1:0];
        wdata       = pdata;
        pstart_next = pst_dec;
        state_next  = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    sh    <= sh_next;
    pdata <= pdata_next;
    hit   <= hit_next;
    full  <= full_next;
    if (state == ST_RESULT && out_free) begin
      m_tdata <= {4'd0, pcount, vcount, full, hit, (hit ? rdata : '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      vcount   <= '0;
      pstart   <= DEPTH_C;
      oldest   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      vcount <= vcount_next;
      pstart <= pstart_next;
      oldest <= oldest_next;
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/two_region_event_buffer_core.sv =====
// Top level of the two-region event buffer: config register, front and back ends.
//
//   port group   direction  beat content
//   s_*          in         one command (clear, append, read)
//   m_*          out        one result per command
//   p*           in/out     APB register access (persistent_floor at 0x0)
//
// Each result is registered in the back end's result state once the output
// slot is free; a persistent append that evicts a volatile entry first moves
// up to DEPTH-1 entries in the shift state, paced by the single write port of
// the entry store. Reset clears pointers and queues and sets persistent_floor
// to 128; store contents are undefined until written. A two-beat queue keeps
// input beats flowing while the back end works or the result is stalled.
`include "two_region_event_buffer_core_defines.svh"

module two_region_event_buffer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // cmd[2:0], event_data[34:3], item_index[42:35], zero fill above
  input  logic [treb_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // event_out[31:0], hit[32], persistent_full[33], volatile_count[42:34],
  // persistent_count[51:43], zero fill above
  output logic [treb_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [treb_pkg::CW-1:0] persistent_floor;
  logic                    item_valid;
  logic                    item_ready;
  treb_pkg::item_t         item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {23'd0, persistent_floor} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      persistent_floor <= treb_pkg::CW'(128);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      persistent_floor <= pwdata[treb_pkg::CW-1:0];
    end
  end

  treb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  treb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .floor      (persistent_floor),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // the two regions never hold more than the store
  `TREB_ASSERT_NOW(a_sizes_fit, m_tvalid,
    ({1'b0, m_tdata[42:34]} + {1'b0, m_tdata[51:43]}) <= 10'(treb_pkg::DEPTH))
  // a refused append is never also a read hit
  `TREB_ASSERT_NOW(a_hit_not_full, m_tvalid, !(m_tdata[32] && m_tdata[33]))
  // misses and non-reads carry a zero payload
  `TREB_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tdata[32], m_tdata[31:0] == 32'd0)
  // back end holds one command at a time: it takes no new work until it returns to idle
  `TREB_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready)

endmodule

// ===== verif/tb_two_region_event_buffer_core.sv =====
// Self-checking testbench for the two-region event buffer core.
module tb_two_region_event_buffer_core;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] data;
    logic [7:0]  idx;
  } cmd_beat_t;

  typedef struct packed {
    logic [31:0] event_out;
    logic        hit;
    logic        full;
    logic [8:0]  vcount;
    logic [8:0]  pcount;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [treb_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [treb_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  two_region_event_buffer_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [31:0] mirror_store [treb_pkg::DEPTH];
  int unsigned m_oldest, m_vcount, m_pstart, m_floor;

  cmd_beat_t pending_cmds[$];
  result_t   expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int hits_seen = 0, fulls_seen = 0;
  int send_idle_pct = 9, recv_idle_pct = 49;
  longint cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
             results_seen);
    errors++;
  endtask

  function automatic result_t buffer_predict(input cmd_beat_t b);
    result_t r;
    int unsigned pos;
    r = '0;
    case (b.cmd)
      treb_pkg::CMD_CLEAR: begin
        m_oldest = 0; m_vcount = 0; m_pstart = treb_pkg::DEPTH;
      end
      treb_pkg::CMD_APPEND_V: begin
        if (m_vcount == m_pstart) begin
          if (m_vcount != 0) begin
            mirror_store[m_oldest] = b.data;
            m_oldest = (m_oldest + 1 >= m_vcount) ? 0 : m_oldest + 1;
          end
        end else if (m_vcount < treb_pkg::DEPTH) begin
          mirror_store[m_vcount] = b.data;
          m_vcount++;
        end
      end
      treb_pkg::CMD_APPEND_P: begin
        if (m_pstart <= m_floor || m_pstart == 0) r.full = 1'b1;
        else begin
          if (m_vcount == m_pstart && m_vcount > 0) begin
            if (m_oldest + 1 >= m_vcount) m_oldest = 0;
            else
              for (int i = m_oldest; i + 1 < m_vcount; i++)
                mirror_store[i] = mirror_store[i+1];
            m_vcount--;
          end
          m_pstart--;
          mirror_store[m_pstart] = b.data;
        end
      end
      treb_pkg::CMD_READ_V: begin
        if (b.idx < m_vcount) begin
          pos = (m_oldest + b.idx) % m_vcount;
          r.event_out = mirror_store[pos];
          r.hit = 1'b1;
        end
      end
      treb_pkg::CMD_READ_P: begin
        if (b.idx < treb_pkg::DEPTH - m_pstart) begin
          r.event_out = mirror_store[treb_pkg::DEPTH-1-b.idx];
          r.hit = 1'b1;
        end
      end
      default: ;
    endcase
    r.vcount = m_vcount[8:0];
    r.pcount = 9'(treb_pkg::DEPTH - m_pstart);
    return r;
  endfunction

  // driver: predicts at acceptance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(buffer_predict(pending_cmds.pop_front()));
      end
      if ((!s_tvalid || s_tready)) begin
        if (pending_cmds.size() > (s_tvalid && s_tready ? 0 : 0) &&
            pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= {5'b0, pending_cmds[0].idx, pending_cmds[0].data, pending_cmds[0].cmd};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[42:34], m_tdata[51:43]};
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.hit) hits_seen <= hits_seen + 1;
          if (got.full) fulls_seen <= fulls_seen + 1;
          if (got.event_out !== want.event_out)
            report_mismatch("event_out", got.event_out, want.event_out);
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.full !== want.full) report_mismatch("persistent_full", got.full, want.full);
          if (got.vcount !== want.vcount)
            report_mismatch("volatile_count", got.vcount, want.vcount);
          if (got.pcount !== want.pcount)
            report_mismatch("persistent_count", got.pcount, want.pcount);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > 64'd3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // sequence generators
  function automatic cmd_beat_t mk(input logic [2:0] c, input logic [31:0] d,
                                   input int unsigned i);
    cmd_beat_t b;
    b.cmd = c; b.data = d; b.idx = 8'(i);
    return b;
  endfunction

  task automatic apb_write_floor(input logic [8:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= {23'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    m_floor = v;
    @(posedge clk);
    if (prdata !== {23'b0, v} || pready !== 1'b1)
      report_mismatch("persistent_floor readback", prdata, {23'b0, v});
  endtask

  task automatic drain;
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // random traffic; starts with a clear so any read hit returns written data
  task automatic random_phase(input int n);
    int r;
    pending_cmds.push_back(mk(treb_pkg::CMD_CLEAR, $urandom, $urandom));
    for (int k = 1; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 1) pending_cmds.push_back(mk(treb_pkg::CMD_CLEAR, $urandom, $urandom));
      else if (r < 35)
        pending_cmds.push_back(mk(treb_pkg::CMD_APPEND_V, $urandom, $urandom));
      else if (r < 50)
        pending_cmds.push_back(mk(treb_pkg::CMD_APPEND_P, $urandom, $urandom));
      else if (r < 72)
        pending_cmds.push_back(mk(treb_pkg::CMD_READ_V, $urandom,
                               $urandom_range(3) == 0 ? $urandom : $urandom_range(15)));
      else if (r < 94)
        pending_cmds.push_back(mk(treb_pkg::CMD_READ_P, $urandom,
                               $urandom_range(3) == 0 ? $urandom : $urandom_range(15)));
      else pending_cmds.push_back(mk(3'($urandom_range(7, 5)), $urandom, $urandom));
    end
  endtask

  initial begin
    m_oldest = 0; m_vcount = 0; m_pstart = treb_pkg::DEPTH; m_floor = 128;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed: empty reads, extremes, undefined commands and clear
    pending_cmds.push_back(mk(treb_pkg::CMD_READ_V, 0, 0));
    pending_cmds.push_back(mk(treb_pkg::CMD_READ_P, 0, 8'hFF));
    pending_cmds.push_back(mk(treb_pkg::CMD_APPEND_V, 32'hFFFFFFFF, 8'hFF));
    pending_cmds.push_back(mk(treb_pkg::CMD_APPEND_V, 32'h0, 0));
    pending_cmds.push_back(mk(treb_pkg::CMD_APPEND_P, 32'hA5A5A5A5, 0));
    pending_cmds.push_back(mk(treb_pkg::CMD_READ_V, 0, 1));
    pending_cmds.push_back(mk(treb_pkg::CMD_READ_V, 0, 2));
    pending_cmds.push_back(mk(treb_pkg::CMD_READ_P, 0, 0));
    pending_cmds.push_back(mk(3'd7, 32'hFFFFFFFF, 8'hFF));
    pending_cmds.push_back(mk(3'd5, 0, 0));
    pending_cmds.push_back(mk(treb_pkg::CMD_CLEAR, 0, 0));
    pending_cmds.push_back(mk(treb_pkg::CMD_READ_V, 0, 0));
    drain();
    // floor 0: fill volatile, then collide and evict by persistent appends
    apb_write_floor(9'd0);
    send_idle_pct = 9; recv_idle_pct = 49;
    for (int k = 0; k < 300; k++)
      pending_cmds.push_back(mk(treb_pkg::CMD_APPEND_V, $urandom, 0));
    for (int k = 0; k < 8; k++)
      pending_cmds.push_back(mk(treb_pkg::CMD_READ_V, 0, $urandom));
    for (int k = 0; k < 258; k++) begin
      pending_cmds.push_back(mk(treb_pkg::CMD_APPEND_P, $urandom, 0));
      if (k % 16 == 0) pending_cmds.push_back(mk(treb_pkg::CMD_READ_V, 0, $urandom));
    end
    pending_cmds.push_back(mk(treb_pkg::CMD_APPEND_V, $urandom, 0));
    pending_cmds.push_back(mk(treb_pkg::CMD_READ_P, 0, 8'hFF));
    drain();
    apb_write_floor(9'd256);
    random_phase(200);
    drain();
    send_idle_pct = 49; recv_idle_pct = 9;
    apb_write_floor(9'd250);
    random_phase(350);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    apb_write_floor(9'(240 + $urandom_range(15)));
    random_phase(350);
    drain();
    $display("covered %0d results, %0d read hits, %0d refused persistent appends",
             results_seen, hits_seen, fulls_seen);
    $display("floor settings 128, 0, 256, 250 and random; wrap and eviction exercised");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
